[rtl/gem_pkg.sv]
// Shared constants, types and the controller state encoding of the gradient magnitude block.
`timescale 1ns / 1ps

package gem_pkg;

  // Line geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int ROW_W     = HEIGHT_W + 1;
  localparam int PIX_W     = 8;

  // Arithmetic widths of the root unit.
  localparam int ROOT_W    = 8;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SQ_W      = RAD_W + 1;

  // Configuration port.
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_MODE    = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;

  // Field codes.
  localparam logic REQ_FLUSH    = 1'b1;
  localparam logic MODE_PREWITT = 1'b1;

  // One line store entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_pair_t;

  // Status of the square root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } state_t;

endpackage

[rtl/gradient_edge_magnitude_3x3.sv]
// Top level: 3x3 Sobel or Prewitt gradient magnitude over a raster pixel stream.
//
//   channel | direction | transfer when            | payload
//   --------+-----------+--------------------------+------------------------------------------
//   in_     | slave     | in_tvalid & in_tready    | tdata: pixel; tuser: req_type
//   out_    | master    | out_tvalid & out_tready  | tdata: magnitude, x, y; tlast: frame_last
//   cfg_    | APB slave | psel & penable & pwrite  | frame_width, frame_height, mask_mode
//
// An interior pixel passes the read, sum, square, root and done states before its result is loaded
// into the output register, the root state waiting on the eight iterations of the square root unit;
// border pixels skip the square and root states and flush items go from idle straight to done. One
// item is in work at a time, and the next is taken while a result waits.
// Reset clears the counters, the window and the controller; the line stores are not cleared.
// A stalled output holds its result and blocks the controller only when a second one is ready.
`timescale 1ns / 1ps

module gradient_edge_magnitude_3x3 (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: pixel[7:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  // in_tuser: req_type[0]
  input  logic [0:0]                  in_tuser,
  // out_tdata: magnitude[7:0], x_response[15:8], y_response[23:16]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gem_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [gem_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [gem_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import gem_pkg::*;

  // Configuration registers.
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                mode_r;
  logic                cfg_wr;
  logic                cfg_geom_wr;
  logic [WIDTH_W-1:0]  width_in;
  logic [HEIGHT_W-1:0] height_in;

  // Frame position.
  logic [COL_W-1:0]    col_r;
  logic [ROW_W-1:0]    row_r;
  logic [WIDTH_W-1:0]  col_inc;
  logic                pix_phase;
  logic                in_xfer;
  logic                ignored;
  logic                emit;
  logic                interior;
  logic                last;

  // Item under work.
  logic                emit_r;
  logic                interior_r;
  logic                last_r;
  logic [COL_W-1:0]    addr_r;
  logic [PIX_W-1:0]    pix_r;

  // Line store and window.
  line_pair_t          line_mem [MAX_WIDTH];
  line_pair_t          rd_q;
  logic [PIX_W-1:0]    taps_r [9];

  // Arithmetic.
  logic [11:0]         x_pos;
  logic [11:0]         x_neg;
  logic [11:0]         y_pos;
  logic [11:0]         y_neg;
  logic [11:0]         x_diff;
  logic [11:0]         y_diff;
  logic [PIX_W-1:0]    x_r;
  logic [PIX_W-1:0]    y_r;
  logic [SQ_W-1:0]     sq_sum;
  logic [ROOT_W-1:0]   root;
  root_stat_t          root_st;

  // Controller.
  state_t              state_r;
  state_t              state_nxt;
  logic                mem_rd;
  logic                mem_wr;
  logic                sum_en;
  logic                root_start;
  logic                out_load;
  logic                out_valid_r;
  logic [23:0]         out_data_r;
  logic                out_last_r;

  // Clamp a signed correlation to the byte range.
  function automatic logic [PIX_W-1:0] clamp_byte(input logic [11:0] v);
    logic [PIX_W-1:0] res;
    if (v[11]) begin
      res = '0;
    end else if (v > 12'd255) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port.

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_geom_wr = cfg_wr && (cfg_paddr[3:2] == REG_FRAME_WIDTH ||
                                  cfg_paddr[3:2] == REG_FRAME_HEIGHT);

  // Written values are saturated to the supported geometry.
  always_comb begin
    width_in  = cfg_pwdata[WIDTH_W-1:0];
    height_in = cfg_pwdata[HEIGHT_W-1:0];
    if (width_in < WIDTH_MIN) begin
      width_in = WIDTH_MIN;
    end else if (width_in > WIDTH_MAX) begin
      width_in = WIDTH_MAX;
    end
    if (height_in < HEIGHT_MIN) begin
      height_in = HEIGHT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FRAME_WIDTH:  width_r  <= width_in;
        REG_FRAME_HEIGHT: height_r <= height_in;
        REG_MASK_MODE:    mode_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the stored values.
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FRAME_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = DATA_W'(height_r);
      REG_MASK_MODE:    cfg_prdata = DATA_W'(mode_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Frame position and per-item classification at the input transfer.

  assign in_xfer   = in_tvalid && in_tready;
  assign pix_phase = row_r < ROW_W'(height_r);
  assign ignored   = pix_phase && (in_tuser[0] == REQ_FLUSH);
  assign emit      = !(row_r == '0 || (row_r == ROW_W'(1) && col_r == '0));
  assign interior  = pix_phase && row_r >= ROW_W'(2) && col_r >= COL_W'(2);
  assign last      = row_r == ROW_W'(height_r) + ROW_W'(1) && col_r == '0;
  assign col_inc   = WIDTH_W'(col_r) + WIDTH_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_geom_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer && !ignored) begin
      if (last) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_inc >= width_r) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // Capture what the item needs downstream.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      emit_r     <= emit;
      interior_r <= interior;
      last_r     <= last;
      addr_r     <= col_r;
      pix_r      <= in_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: read the column on transfer, write the shifted pair in the next cycle.

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_q <= line_mem[col_r];
    end
    if (mem_wr) begin
      line_mem[addr_r] <= '{upper: rd_q.lower, lower: pix_r};
    end
  end

  // Window shifts left by one column; the new column comes from the store and the pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        taps_r[i] <= '0;
      end
    end else if (mem_wr) begin
      for (int k = 0; k < 3; k++) begin
        taps_r[k*3]   <= taps_r[k*3+1];
        taps_r[k*3+1] <= taps_r[k*3+2];
      end
      taps_r[2] <= rd_q.upper;
      taps_r[5] <= rd_q.lower;
      taps_r[8] <= pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Mask correlation; the middle weight is two for Sobel and one for Prewitt.

  always_comb begin
    x_pos = 12'(taps_r[0]) + 12'(taps_r[6]) +
            ((mode_r == MODE_PREWITT) ? 12'(taps_r[3]) : {3'b0, taps_r[3], 1'b0});
    x_neg = 12'(taps_r[2]) + 12'(taps_r[8]) +
            ((mode_r == MODE_PREWITT) ? 12'(taps_r[5]) : {3'b0, taps_r[5], 1'b0});
    y_pos = 12'(taps_r[0]) + 12'(taps_r[2]) +
            ((mode_r == MODE_PREWITT) ? 12'(taps_r[1]) : {3'b0, taps_r[1], 1'b0});
    y_neg = 12'(taps_r[6]) + 12'(taps_r[8]) +
            ((mode_r == MODE_PREWITT) ? 12'(taps_r[7]) : {3'b0, taps_r[7], 1'b0});
    x_diff = x_pos - x_neg;
    y_diff = y_pos - y_neg;
  end

  // Responses are zero on the border and for flush items.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= '0;
      y_r <= '0;
    end else if (sum_en && interior_r) begin
      x_r <= clamp_byte(x_diff);
      y_r <= clamp_byte(y_diff);
    end
  end

  assign sq_sum = SQ_W'(RAD_W'(x_r) * RAD_W'(x_r)) + SQ_W'(RAD_W'(y_r) * RAD_W'(y_r));

  gem_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sq_sum),
    .root  (root),
    .stat  (root_st)
  );

  // ---------------------------------------------------------------------------
  // Controller.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    sum_en     = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !ignored) begin
          if (pix_phase) begin
            mem_rd    = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        mem_wr    = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_en = 1'b1;
        if (!emit_r) begin
          state_nxt = S_IDLE;
        end else if (interior_r) begin
          state_nxt = S_SQUARE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SQUARE: begin
        root_start = 1'b1;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        if (root_st.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {y_r, x_r, (interior_r ? root : {ROOT_W{1'b0}})};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks.

  // The magnitude never falls below either response.
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] >= out_tdata[15:8] && out_tdata[7:0] >= out_tdata[23:16])
    else $error("magnitude below a response");

  // The root unit finishes only while the controller waits for it.
  a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_st.done |-> state_r == S_ROOT)
    else $error("root result outside the root state");

  // A pixel transfer is followed by the line store write-back.
  a_pixel_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !ignored && pix_phase && !cfg_geom_wr |=> state_r == S_READ)
    else $error("pixel transfer without store access");

  // The column counter stays inside the row.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> WIDTH_W'(col_r) < width_r)
    else $error("column counter beyond frame width");

  // A flush item never touches the line store.
  a_flush_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !pix_phase |=> !mem_wr && state_r != S_READ)
    else $error("flush item reached the line store");

endmodule

[rtl/gem_root.sv]
// Iterative floor square root unit, saturated to eight bits, one result bit per cycle.
`timescale 1ns / 1ps

module gem_root (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gem_pkg::SQ_W-1:0]   value,
  output logic [gem_pkg::ROOT_W-1:0] root,
  output gem_pkg::root_stat_t        stat
);
  import gem_pkg::*;

  logic [RAD_W-1:0]  val_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W-1:0] bit_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W-1:0] trial;
  logic [RAD_W-1:0]  trial_sq;

  // Candidate with the current bit set, and its square.
  assign trial    = root_r | bit_r;
  assign trial_sq = RAD_W'(trial) * RAD_W'(trial);

  // Control: busy while the result bits are resolved, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Radicand is saturated to sixteen bits, whose root saturates at the top code.
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value[SQ_W-1] ? {RAD_W{1'b1}} : value[RAD_W-1:0];
      root_r <= '0;
      bit_r  <= {1'b1, {(ROOT_W-1){1'b0}}};
    end else if (busy_r) begin
      if (trial_sq <= val_r) begin
        root_r <= trial;
      end
      bit_r <= bit_r >> 1;
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // The trial bit walks down one position at a time while busy.
  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot(bit_r))
    else $error("root trial bit is not one-hot");

  // Done follows the final iteration and never overlaps a running one.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("root done without a completed iteration");

  // A new root is started only when the unit is free.
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("root started while busy");

endmodule
